/* design/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants, codes, controller/datapath interface types and helper
// functions of the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int BASE_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;

	// one stored digit per bit of value covers the smallest output base
	localparam int DEPTH  = VALUE_BITS;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int BCNT_W = $clog2(VALUE_BITS);
	localparam int PROD_W = VALUE_BITS + BASE_W;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 2'd1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FRACTION  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

	localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
	localparam logic [BASE_W-1:0] BASE_LIMIT   = 6'd36;
	localparam logic [BASE_W-1:0] IN_BASE_RST  = 6'd10;
	localparam logic [BASE_W-1:0] OUT_BASE_RST = 6'd2;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] CH_ALPHA   = 8'd55;
	localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;

	typedef struct packed {
		logic take;        // capture the input item
		logic acc;         // fold the captured character into the value
		logic emit_err;    // load the single error result
		logic div_init;    // start one digit division
		logic load_acc;    // with div_init: start from the accumulated value
		logic div_step;    // one restoring division step
		logic emit_digit;  // load the next stored digit as a result
	} rsc_cmd_t;

	typedef struct packed {
		logic final_q;     // captured item closes the number
		logic err_set;     // an error was recorded in this run
		logic div_last;    // division step counter at its last step
		logic quot_zero;   // quotient left after a digit is zero
		logic last_digit;  // one stored digit left
		logic out_free;    // output register can take a result
	} rsc_stat_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		begin
			r = b;
			if (b < BASE_MIN) r = BASE_MIN;
			else if (b > BASE_LIMIT) r = BASE_LIMIT;
			return r;
		end
	endfunction

	// MSB set: not a digit character
	function automatic logic [BASE_W:0] char_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		logic [BASE_W:0]   r;
		begin
			r = {1'b1, {BASE_W{1'b0}}};
			d = '0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				r = {1'b0, d[BASE_W-1:0]};
			end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
				d = c - CH_ALPHA;
				r = {1'b0, d[BASE_W-1:0]};
			end
			return r;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		begin
			dx = {{(CHAR_W-BASE_W){1'b0}}, d};
			return (d > 6'd9) ? dx + CH_ALPHA : dx + CH_ZERO;
		end
	endfunction

endpackage

/* design/rsc_ctrl.sv */
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer of the radix string converter: accepts items, steps the
// accumulate, division and result emission phases of the datapath.
// ----------------------------------------------------------------------------
module rsc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rsc_pkg::rsc_stat_t stat,
	output rsc_pkg::rsc_cmd_t  cmd
);
	import rsc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_FIN  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DCHK = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_n = stat.final_q ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				if (stat.err_set) begin
					if (stat.out_free) begin
						cmd.emit_err = 1'b1;
						state_n      = S_IDLE;
					end
				end else begin
					cmd.div_init = 1'b1;
					cmd.load_acc = 1'b1;
					state_n      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_n = S_DCHK;
			end
			S_DCHK: begin
				// keep dividing until the quotient runs out
				if (stat.quot_zero) begin
					state_n = S_EMIT;
				end else begin
					cmd.div_init = 1'b1;
					state_n      = S_DIV;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					if (stat.last_digit) state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

/* design/rsc_dpath.sv */
// ----------------------------------------------------------------------------
// rsc_dpath
// Datapath of the radix string converter: configuration registers,
// multiply-add accumulator with error tracking, bit-serial divider,
// digit store and output register.
// ----------------------------------------------------------------------------
module rsc_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsc_pkg::BASE_W-1:0]      cfg_data,
	input  logic [rsc_pkg::CHAR_W-1:0]      digit_char,
	input  logic                            final_char,
	input  logic                            out_ready,
	input  rsc_pkg::rsc_cmd_t               cmd,
	output rsc_pkg::rsc_stat_t              stat,
	output logic                            out_valid,
	output logic [rsc_pkg::CHAR_W-1:0]      out_char,
	output logic [rsc_pkg::STATUS_W-1:0]    status,
	output logic                            last_out
);
	import rsc_pkg::*;

	logic [BASE_W-1:0]     in_base_q;
	logic [BASE_W-1:0]     out_base_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  final_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [STATUS_W-1:0]   err_q;
	logic [PROD_W-1:0]     prod_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [BASE_W-1:0]     rem_q;
	logic [BCNT_W-1:0]     bcnt_q;
	logic [CNT_W-1:0]      dcnt_q;
	logic [BASE_W-1:0]     store_q [DEPTH];
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  last_q;

	logic [BASE_W-1:0]     in_b;
	logic [BASE_W-1:0]     out_b;
	logic [BASE_W:0]       cv;
	logic [BASE_W-1:0]     dig;
	logic                  bad;
	logic [PROD_W-1:0]     sum;
	logic                  ovf;
	logic                  locked;
	logic [BASE_W:0]       r_sh;
	logic                  ge;
	logic [BASE_W:0]       r_diff;
	logic [BASE_W-1:0]     r_nx;
	logic [VALUE_BITS-1:0] q_nx;
	logic [IDX_W-1:0]      rd_idx;
	logic                  clear_run;
	logic                  out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= IN_BASE_RST;
			out_base_q <= OUT_BASE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_IN_BASE) in_base_q <= cfg_data;
			else if (cfg_index == REG_OUT_BASE) out_base_q <= cfg_data;
		end
	end

	assign in_b  = clamp_base(in_base_q);
	assign out_b = clamp_base(out_base_q);

	// accumulate: product is registered while the block waits for an item
	assign cv     = char_value(char_q);
	assign dig    = cv[BASE_W-1:0];
	assign bad    = cv[BASE_W] || (dig >= in_b);
	assign sum    = prod_q + PROD_W'(dig);
	assign ovf    = sum > PROD_W'(VALUE_MAX);
	assign locked = (err_q == ST_BAD_DIGIT) || (err_q == ST_FRACTION);

	assign clear_run = cmd.emit_err || (cmd.emit_digit && stat.last_digit);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(acc_q) * PROD_W'(in_b);
		if (cmd.take) begin
			char_q  <= digit_char;
			final_q <= final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= ST_OK;
		end else if (clear_run) begin
			acc_q <= '0;
			err_q <= ST_OK;
		end else if (cmd.acc && !locked) begin
			if (char_q == CH_POINT) begin
				err_q <= ST_FRACTION;
			end else if (bad) begin
				err_q <= ST_BAD_DIGIT;
			end else if (ovf) begin
				acc_q <= VALUE_MAX;
				err_q <= ST_OVERFLOW;
			end else begin
				acc_q <= sum[VALUE_BITS-1:0];
			end
		end
	end

	// restoring division, one quotient bit per step
	assign r_sh   = {rem_q, div_q[VALUE_BITS-1]};
	assign ge     = r_sh >= {1'b0, out_b};
	assign r_diff = r_sh - {1'b0, out_b};
	assign r_nx   = ge ? r_diff[BASE_W-1:0] : r_sh[BASE_W-1:0];
	assign q_nx   = {div_q[VALUE_BITS-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			if (cmd.load_acc) div_q <= acc_q;
		end else if (cmd.div_step) begin
			rem_q <= r_nx;
			div_q <= q_nx;
			if (bcnt_q == '0) store_q[dcnt_q[IDX_W-1:0]] <= r_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.div_init) begin
				bcnt_q <= BCNT_W'(VALUE_BITS - 1);
				if (cmd.load_acc) dcnt_q <= '0;
			end else if (cmd.div_step) begin
				bcnt_q <= bcnt_q - 1'b1;
				if (bcnt_q == '0) dcnt_q <= dcnt_q + 1'b1;
			end else if (cmd.emit_digit) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// emit most significant digit first
	assign rd_idx   = IDX_W'(dcnt_q - 1'b1);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_char_q <= '0;
			status_q   <= err_q;
			last_q     <= 1'b1;
		end else if (cmd.emit_digit) begin
			out_char_q <= digit_ascii(store_q[rd_idx]);
			status_q   <= ST_OK;
			last_q     <= stat.last_digit;
		end
	end

	assign stat.final_q    = final_q;
	assign stat.err_set    = (err_q != ST_OK);
	assign stat.div_last   = (bcnt_q == '0);
	assign stat.quot_zero  = (div_q == '0);
	assign stat.last_digit = (dcnt_q == CNT_W'(1));
	assign stat.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign status    = status_q;
	assign last_out  = last_q;

	a_dcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= CNT_W'(DEPTH))
		else $error("digit count beyond store depth");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |-> dcnt_q != '0)
		else $error("digit emitted from empty store");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> rem_q < out_b)
		else $error("division remainder not below base");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> out_valid_q && last_q && out_char_q == '0 && status_q != ST_OK)
		else $error("malformed error result");

endmodule

/* design/radix_string_converter_top.sv */
// Sequence: a non-final character is accepted, then folded in by a multiply-add.
// A final character with a recorded error gives its result after the multiply-add.
// Otherwise each output digit takes 31 steps in the bit-serial divider plus a
// quotient check; then results leave one per cycle while the output can take them.
// One item is in flight at a time; output stalls hold the results back.
// Reset: bases return to 10 and 2, run state clears; the digit store is not cleared.
// ----------------------------------------------------------------------------
// radix_string_converter_top
// Converts a character stream of an unsigned number from one radix into
// ASCII digits of another radix, with digit, fraction and overflow errors.
// ----------------------------------------------------------------------------
module radix_string_converter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsc_pkg::BASE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rsc_pkg::CHAR_W-1:0]    digit_char,
	input  logic                          final_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rsc_pkg::CHAR_W-1:0]    out_char,
	output logic [rsc_pkg::STATUS_W-1:0]  status,
	output logic                          last_out
);
	import rsc_pkg::*;

	rsc_cmd_t  cmd;
	rsc_stat_t stat;

	assign cfg_ready = 1'b1;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsc_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.digit_char (digit_char),
		.final_char (final_char),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_char   (out_char),
		.status     (status),
		.last_out   (last_out)
	);

endmodule

/* sim/tb_radix_string_converter_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_string_converter_top
// Sends digit character streams to the radix converter, predicts the emitted
// ASCII digits and error results in the bench, and compares every result.
// ----------------------------------------------------------------------------
module tb_radix_string_converter_top;
	import rsc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam longint unsigned ACC_MAX = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct packed {
		logic [CHAR_W-1:0]   ch;
		logic [STATUS_W-1:0] st;
		logic                last;
	} conv_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BASE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CHAR_W-1:0]    digit_char = '0;
	logic                 final_char = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b1;
	logic [CHAR_W-1:0]    out_char;
	logic [STATUS_W-1:0]  status;
	logic                 last_out;

	// bench copy of the converter state
	logic [BASE_W-1:0]   in_radix_reg = IN_BASE_RST;
	logic [BASE_W-1:0]   out_radix_reg = OUT_BASE_RST;
	longint unsigned     value_acc = 0;
	logic [STATUS_W-1:0] run_status = ST_OK;

	conv_result_t pending_digits[$];

	int  err_count = 0;
	int  cycle_count = 0;
	int  chars_sent = 0;
	int  numbers_sent = 0;
	int  results_checked = 0;
	int  error_results = 0;
	int  ready_hold = 0;
	bit  calm = 1'b0;

	radix_string_converter_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.digit_char (digit_char),
		.final_char (final_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.status     (status),
		.last_out   (last_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			pending_digits.size());
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int unsigned usable_radix(input logic [BASE_W-1:0] b);
		if (b < 2) return 2;
		if (b > 36) return 36;
		return 32'(b);
	endfunction

	function automatic logic [CHAR_W-1:0] digit_glyph(input int unsigned d);
		return (d > 9) ? CH_ALPHA + CHAR_W'(d) : CH_ZERO + CHAR_W'(d);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit(input int unsigned radix);
		return digit_glyph($urandom_range(0, radix - 1));
	endfunction

	function automatic logic [BASE_W-1:0] pick_radix();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd1;
			2: return BASE_MIN;
			3: return BASE_LIMIT;
			4: return 6'd37;
			5: return 6'd63;
			default: return BASE_W'($urandom_range(3, 35));
		endcase
	endfunction

	// append one result to the tail of the expected queue
	function automatic void add_expected(input conv_result_t r);
		pending_digits = {pending_digits, r};
	endfunction

	// fold one character into the value and queue the digits of a closed number
	function automatic void predict_char(input logic [CHAR_W-1:0] c, input logic fin);
		longint unsigned radix;
		longint unsigned dv;
		longint unsigned v;
		int unsigned     digs[$];
		conv_result_t    r;
		radix = usable_radix(in_radix_reg);
		if (run_status != ST_BAD_DIGIT && run_status != ST_FRACTION) begin
			if (c == CH_POINT) begin
				run_status = ST_FRACTION;
			end else begin
				if (c >= CH_ZERO && c <= CH_NINE) dv = 64'(c - CH_ZERO);
				else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) dv = 64'(c - CH_ALPHA);
				else dv = 255;
				if (dv >= radix) begin
					run_status = ST_BAD_DIGIT;
				end else if (value_acc > (ACC_MAX - dv) / radix) begin
					value_acc = ACC_MAX;
					run_status = ST_OVERFLOW;
				end else begin
					value_acc = value_acc * radix + dv;
				end
			end
		end
		if (!fin) return;
		if (run_status != ST_OK) begin
			r.ch = '0;
			r.st = run_status;
			r.last = 1'b1;
			add_expected(r);
		end else begin
			radix = usable_radix(out_radix_reg);
			v = value_acc;
			do begin
				digs.push_front(32'(v % radix));
				v = v / radix;
			end while (v != 0);
			foreach (digs[i]) begin
				r.ch = digit_glyph(digs[i]);
				r.st = ST_OK;
				r.last = (i == digs.size() - 1);
				add_expected(r);
			end
		end
		value_acc = 0;
		run_status = ST_OK;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_count++;
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		conv_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (status != ST_OK) error_results++;
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected item char=%02h status=%0d last=%0b",
					out_char, status, last_out));
			end else begin
				e = pending_digits.pop_front();
				if (out_char !== e.ch)
					report_mismatch($sformatf("out_char %02h, want %02h", out_char, e.ch));
				if (status !== e.st)
					report_mismatch($sformatf("status %0d, want %0d", status, e.st));
				if (last_out !== e.last)
					report_mismatch($sformatf("last_out %0b, want %0b", last_out, e.last));
			end
		end
	end

	// output stalls: random bursts with out_ready held low
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			out_ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
		in_valid <= 1'b1;
		digit_char <= c;
		final_char <= fin;
		do @(posedge clk); while (!in_ready);
		predict_char(c, fin);
		chars_sent++;
		if (fin) numbers_sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i], i == txt.len() - 1);
	endtask

	// hold input until every predicted item is out, then let a pending character settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IN_BASE) in_radix_reg = data;
		else if (idx == REG_OUT_BASE) out_radix_reg = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_bases();
		send_text("0");
		send_text("19");
		send_text(".");
		send_char(8'd97, 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("A");
		drain_results();
	endtask

	task automatic test_value_limits();
		// base 36 in, base 2 out: largest value gives 31 ones, one more overflows
		write_reg(REG_IN_BASE, 6'd63);
		write_reg(REG_OUT_BASE, 6'd0);
		send_text("ZIK0ZJ");
		send_text("ZIK0ZK");
		drain_results();
	endtask

	task automatic test_error_rules();
		write_reg(REG_IN_BASE, 6'd1);
		write_reg(REG_OUT_BASE, 6'd37);
		// bad digit after the point is ignored
		send_char(CH_POINT, 1'b0);
		send_char(8'd97, 1'b1);
		send_text("2");
		send_text("1");
		drain_results();
		write_reg(REG_IN_BASE, BASE_LIMIT);
		write_reg(REG_OUT_BASE, BASE_LIMIT);
		send_text("Z");
		drain_results();
	endtask

	task automatic test_random_streams(input int n_chars);
		int          sent;
		int          setting;
		int          len;
		bit          paused;
		int unsigned radix;
		logic [CHAR_W-1:0] c;
		sent = 0;
		setting = 0;
		paused = 1'b0;
		while (sent < n_chars) begin
			if (sent >= setting * 35) begin
				drain_results();
				write_reg(REG_IN_BASE, pick_radix());
				write_reg(REG_OUT_BASE, pick_radix());
				setting++;
			end else if (!paused && sent >= n_chars / 2) begin
				drain_results();
				paused = 1'b1;
			end
			calm = (sent >= n_chars - 30);
			radix = usable_radix(in_radix_reg);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				c = rand_digit(radix);
				if ($urandom_range(0, 14) == 0) c = CHAR_W'($urandom_range(0, 255));
				else if ($urandom_range(0, 29) == 0) c = CH_POINT;
				else if ($urandom_range(0, 39) == 0) c = 8'd97 + CHAR_W'($urandom_range(0, 25));
				send_char(c, k == len - 1);
			end
			sent += len;
		end
		drain_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_bases();
		test_value_limits();
		test_error_rules();
		test_random_streams(210);

		repeat (40) @(posedge clk);
		$display("covered %0d characters in %0d numbers over all base settings",
			chars_sent, numbers_sent);
		$display("checked %0d result items, %0d of them error results",
			results_checked, error_results);
		if (err_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/rsc_pkg.sv
design/rsc_ctrl.sv
design/rsc_dpath.sv
design/radix_string_converter_top.sv
sim/tb_radix_string_converter_top.sv
